### hw/rtl/spwv_pkg.sv
// Shared types and constants for the sector pattern write/verify engine.
`default_nettype none

package spwv_pkg;

    localparam logic [2:0] KIND_GENERATE = 3'd0;
    localparam logic [2:0] KIND_VERIFY   = 3'd1;
    localparam logic [2:0] KIND_WRITE    = 3'd2;
    localparam logic [2:0] KIND_READ     = 3'd3;
    localparam logic [2:0] KIND_RESTART  = 3'd4;

    localparam logic [31:0] SEED_MUL  = 32'd2654435761;
    localparam logic [31:0] SEED_ADD  = 32'hA5A5A5A5;
    localparam logic [31:0] LCG_MUL   = 32'd1664525;
    localparam logic [31:0] LCG_ADD   = 32'd1013904223;
    localparam logic [31:0] GOLDEN    = 32'h9E3779B9;
    localparam logic [31:0] NONE_ADDR = 32'hFFFFFFFF;

    localparam logic [7:0] ABORT_THRESHOLD_RESET = 8'd16;
    localparam logic [7:0] RUN_MAX               = 8'hFF;

    localparam logic [1:0] ABORT_WRITE = 2'b01;
    localparam logic [1:0] ABORT_READ  = 2'b10;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] sector_address;
        logic [6:0]  word_index;
        logic [31:0] read_word;
        logic        io_ok;
        logic [7:0]  chunk_sectors;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pattern_word;
        logic        sector_mismatch;
        logic [31:0] write_fail_count;
        logic [31:0] read_fail_count;
        logic [31:0] mismatch_count;
        logic [31:0] verified_count;
        logic [31:0] written_count;
        logic [31:0] first_write_fail;
        logic [31:0] first_verify_fail;
        logic [31:0] wrap_address;
        logic [31:0] wrap_tag;
        logic [1:0]  abort_flags;
    } out_item_t;

    // One finished transaction handed from the sequencer to the statistics.
    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [31:0] addr;
        logic        first_word;
        logic        last_word;
        logic [31:0] pattern;
        logic [31:0] read_word;
        logic        io_ok;
        logic [7:0]  chunk_sectors;
    } commit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC1,
        ST_MAC2,
        ST_DONE
    } seq_state_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [7:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {25'd0, b};
        return s[32] ? NONE_ADDR : s[31:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/spwv_mac.sv
// Shared 32-bit multiply-add unit with a registered result (low word only).
`default_nettype none

module spwv_mac (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] op_a,
    input  wire logic [31:0] op_b,
    input  wire logic [31:0] op_c,
    output logic      [31:0] result
);

    logic [31:0] prod;
    logic [31:0] sum;
    logic [31:0] result_reg;

    assign prod   = op_a * op_b;
    assign sum    = prod + op_c;
    assign result = result_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= sum;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/spwv_ctrl.sv
// Sequencer: takes one transaction, runs the pattern generator on the shared unit, commits.
`default_nettype none

module spwv_ctrl #(
    parameter int unsigned SECTOR_WORDS = 128
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire spwv_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   mac_en,
    output logic            [31:0] mac_a,
    output logic            [31:0] mac_b,
    output logic            [31:0] mac_c,
    input  wire logic       [31:0] mac_result,
    output spwv_pkg::commit_t      commit
);

    localparam int unsigned LAST_IDX = SECTOR_WORDS - 1;

    spwv_pkg::seq_state_t state_reg, state_next;
    spwv_pkg::in_item_t   item_reg;
    logic [31:0]          tmp_reg;
    logic [31:0]          lcg_reg, lcg_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 is_word;
    logic                 first_word;
    logic                 slot_free;
    logic [31:0]          pattern;

    assign is_word    = item_reg.kind inside {spwv_pkg::KIND_GENERATE, spwv_pkg::KIND_VERIFY};
    assign first_word = (item_reg.word_index == 7'd0);
    assign slot_free  = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == spwv_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spwv_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.kind inside {spwv_pkg::KIND_GENERATE, spwv_pkg::KIND_VERIFY})
                    begin
                        state_next = spwv_pkg::ST_MAC1;
                    end
                    else
                    begin
                        state_next = spwv_pkg::ST_DONE;
                    end
                end
            end
            spwv_pkg::ST_MAC1: state_next = spwv_pkg::ST_MAC2;
            spwv_pkg::ST_MAC2: state_next = spwv_pkg::ST_DONE;
            spwv_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = spwv_pkg::ST_IDLE;
                end
            end
            default: state_next = spwv_pkg::ST_IDLE;
        endcase
    end

    // The first step builds either the seed or the index term; the second advances the LCG.
    always_comb
    begin
        mac_en = 1'b0;
        mac_a  = item_reg.sector_address;
        mac_b  = spwv_pkg::SEED_MUL;
        mac_c  = spwv_pkg::SEED_ADD;
        case (state_reg)
            spwv_pkg::ST_MAC1:
            begin
                mac_en = 1'b1;
                if (!first_word)
                begin
                    mac_a = {25'd0, item_reg.word_index};
                    mac_b = spwv_pkg::GOLDEN;
                    mac_c = item_reg.sector_address;
                end
            end
            spwv_pkg::ST_MAC2:
            begin
                mac_en = 1'b1;
                mac_a  = first_word ? mac_result : lcg_reg;
                mac_b  = spwv_pkg::LCG_MUL;
                mac_c  = spwv_pkg::LCG_ADD;
            end
            default: mac_en = 1'b0;
        endcase
    end

    always_comb
    begin
        pattern = 32'd0;
        if (is_word)
        begin
            if (first_word)
            begin
                pattern = item_reg.sector_address;
            end
            else if (item_reg.word_index == 7'd1)
            begin
                pattern = ~item_reg.sector_address;
            end
            else
            begin
                pattern = mac_result ^ tmp_reg;
            end
        end
    end

    always_comb
    begin
        commit.valid         = (state_reg == spwv_pkg::ST_DONE) && slot_free;
        commit.kind          = item_reg.kind;
        commit.addr          = item_reg.sector_address;
        commit.first_word    = first_word;
        commit.last_word     = ({25'd0, item_reg.word_index} == 32'(LAST_IDX));
        commit.pattern       = pattern;
        commit.read_word     = item_reg.read_word;
        commit.io_ok         = item_reg.io_ok;
        commit.chunk_sectors = item_reg.chunk_sectors;
    end

    always_comb
    begin
        lcg_next = lcg_reg;
        if (commit.valid)
        begin
            if (is_word)
            begin
                lcg_next = mac_result;
            end
            else if (item_reg.kind == spwv_pkg::KIND_RESTART)
            begin
                lcg_next = 32'd0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spwv_pkg::ST_IDLE;
            lcg_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lcg_reg       <= lcg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        if (state_reg == spwv_pkg::ST_MAC2)
        begin
            tmp_reg <= mac_result;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/spwv_stats.sv
// Running statistics, sector check state, abort flags and the result payload register.
`default_nettype none

module spwv_stats (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic        [7:0] cfg_wdata,
    input  wire spwv_pkg::commit_t commit,
    output spwv_pkg::out_item_t    result
);

    logic [7:0]  threshold_reg;
    logic [31:0] pattern_reg, pattern_next;
    logic        smis_reg, smis_next;
    logic        bad_reg, bad_next;
    logic [31:0] tag_reg, tag_next;
    logic [7:0]  wrun_reg, wrun_next;
    logic [7:0]  rrun_reg, rrun_next;
    logic [31:0] wfails_reg, wfails_next;
    logic [31:0] rfails_reg, rfails_next;
    logic [31:0] mismatches_reg, mismatches_next;
    logic [31:0] verified_reg, verified_next;
    logic [31:0] written_reg, written_next;
    logic [31:0] first_wfail_reg, first_wfail_next;
    logic [31:0] first_vfail_reg, first_vfail_next;
    logic [31:0] wrap_addr_reg, wrap_addr_next;
    logic [31:0] wrap_tag_reg, wrap_tag_next;
    logic        wfail_vld_reg, wfail_vld_next;
    logic        vfail_vld_reg, vfail_vld_next;
    logic        wrap_vld_reg, wrap_vld_next;
    logic [1:0]  abort_reg, abort_next;
    logic        word_diff;
    logic        restart;

    assign word_diff = (commit.read_word != commit.pattern);
    assign restart   = commit.valid && (commit.kind == spwv_pkg::KIND_RESTART);

    always_comb
    begin
        pattern_next     = pattern_reg;
        smis_next        = smis_reg;
        bad_next         = bad_reg;
        tag_next         = tag_reg;
        wrun_next        = wrun_reg;
        rrun_next        = rrun_reg;
        wfails_next      = wfails_reg;
        rfails_next      = rfails_reg;
        mismatches_next  = mismatches_reg;
        verified_next    = verified_reg;
        written_next     = written_reg;
        first_wfail_next = first_wfail_reg;
        first_vfail_next = first_vfail_reg;
        wrap_addr_next   = wrap_addr_reg;
        wrap_tag_next    = wrap_tag_reg;
        wfail_vld_next   = wfail_vld_reg;
        vfail_vld_next   = vfail_vld_reg;
        wrap_vld_next    = wrap_vld_reg;
        abort_next       = abort_reg;
        if (commit.valid)
        begin
            pattern_next = commit.pattern;
            smis_next    = 1'b0;
            case (commit.kind)
                spwv_pkg::KIND_GENERATE: smis_next = 1'b0;
                spwv_pkg::KIND_VERIFY:
                begin
                    if (commit.first_word)
                    begin
                        tag_next = commit.read_word;
                        bad_next = word_diff;
                    end
                    else
                    begin
                        bad_next = bad_reg | word_diff;
                    end
                    if (commit.last_word)
                    begin
                        smis_next = bad_next;
                        if (bad_next)
                        begin
                            mismatches_next = spwv_pkg::sat_add(mismatches_reg, 8'd1);
                            if (!vfail_vld_reg)
                            begin
                                vfail_vld_next   = 1'b1;
                                first_vfail_next = commit.addr;
                            end
                            if ((tag_next != commit.addr) && !wrap_vld_reg)
                            begin
                                wrap_vld_next  = 1'b1;
                                wrap_addr_next = commit.addr;
                                wrap_tag_next  = tag_next;
                            end
                        end
                        else
                        begin
                            verified_next = spwv_pkg::sat_add(verified_reg, 8'd1);
                        end
                    end
                end
                spwv_pkg::KIND_WRITE:
                begin
                    if (commit.io_ok)
                    begin
                        wrun_next    = 8'd0;
                        written_next = spwv_pkg::sat_add(written_reg, commit.chunk_sectors);
                    end
                    else
                    begin
                        wfails_next = spwv_pkg::sat_add(wfails_reg, 8'd1);
                        if (!wfail_vld_reg)
                        begin
                            wfail_vld_next   = 1'b1;
                            first_wfail_next = commit.addr;
                        end
                        wrun_next = (wrun_reg == spwv_pkg::RUN_MAX) ? wrun_reg : wrun_reg + 8'd1;
                        if (wrun_next >= threshold_reg)
                        begin
                            abort_next = abort_reg | spwv_pkg::ABORT_WRITE;
                        end
                    end
                end
                spwv_pkg::KIND_READ:
                begin
                    if (commit.io_ok)
                    begin
                        rrun_next = 8'd0;
                    end
                    else
                    begin
                        rfails_next = spwv_pkg::sat_add(rfails_reg, 8'd1);
                        if (!vfail_vld_reg)
                        begin
                            vfail_vld_next   = 1'b1;
                            first_vfail_next = commit.addr;
                        end
                        rrun_next = (rrun_reg == spwv_pkg::RUN_MAX) ? rrun_reg : rrun_reg + 8'd1;
                        if (rrun_next >= threshold_reg)
                        begin
                            abort_next = abort_reg | spwv_pkg::ABORT_READ;
                        end
                    end
                end
                spwv_pkg::KIND_RESTART:
                begin
                    bad_next         = 1'b0;
                    tag_next         = 32'd0;
                    wrun_next        = 8'd0;
                    rrun_next        = 8'd0;
                    wfails_next      = 32'd0;
                    rfails_next      = 32'd0;
                    mismatches_next  = 32'd0;
                    verified_next    = 32'd0;
                    written_next     = 32'd0;
                    first_wfail_next = spwv_pkg::NONE_ADDR;
                    first_vfail_next = spwv_pkg::NONE_ADDR;
                    wrap_addr_next   = spwv_pkg::NONE_ADDR;
                    wrap_tag_next    = 32'd0;
                    wfail_vld_next   = 1'b0;
                    vfail_vld_next   = 1'b0;
                    wrap_vld_next    = 1'b0;
                    abort_next       = 2'b00;
                end
                default: smis_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= spwv_pkg::ABORT_THRESHOLD_RESET;
            pattern_reg     <= 32'd0;
            smis_reg        <= 1'b0;
            bad_reg         <= 1'b0;
            tag_reg         <= 32'd0;
            wrun_reg        <= 8'd0;
            rrun_reg        <= 8'd0;
            wfails_reg      <= 32'd0;
            rfails_reg      <= 32'd0;
            mismatches_reg  <= 32'd0;
            verified_reg    <= 32'd0;
            written_reg     <= 32'd0;
            first_wfail_reg <= spwv_pkg::NONE_ADDR;
            first_vfail_reg <= spwv_pkg::NONE_ADDR;
            wrap_addr_reg   <= spwv_pkg::NONE_ADDR;
            wrap_tag_reg    <= 32'd0;
            wfail_vld_reg   <= 1'b0;
            vfail_vld_reg   <= 1'b0;
            wrap_vld_reg    <= 1'b0;
            abort_reg       <= 2'b00;
        end
        else
        begin
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
            pattern_reg     <= pattern_next;
            smis_reg        <= smis_next;
            bad_reg         <= bad_next;
            tag_reg         <= tag_next;
            wrun_reg        <= wrun_next;
            rrun_reg        <= rrun_next;
            wfails_reg      <= wfails_next;
            rfails_reg      <= rfails_next;
            mismatches_reg  <= mismatches_next;
            verified_reg    <= verified_next;
            written_reg     <= written_next;
            first_wfail_reg <= first_wfail_next;
            first_vfail_reg <= first_vfail_next;
            wrap_addr_reg   <= wrap_addr_next;
            wrap_tag_reg    <= wrap_tag_next;
            wfail_vld_reg   <= wfail_vld_next;
            vfail_vld_reg   <= vfail_vld_next;
            wrap_vld_reg    <= wrap_vld_next;
            abort_reg       <= abort_next;
        end
    end

    always_comb
    begin
        result.pattern_word      = pattern_reg;
        result.sector_mismatch   = smis_reg;
        result.write_fail_count  = wfails_reg;
        result.read_fail_count   = rfails_reg;
        result.mismatch_count    = mismatches_reg;
        result.verified_count    = verified_reg;
        result.written_count     = written_reg;
        result.first_write_fail  = first_wfail_reg;
        result.first_verify_fail = first_vfail_reg;
        result.wrap_address      = wrap_addr_reg;
        result.wrap_tag          = wrap_tag_reg;
        result.abort_flags       = abort_reg;
    end

`ifndef SYNTHESIS
    // Abort flags only ever clear on a restart.
    assert property (@(posedge clk) disable iff (!rst_n)
        !restart |=> ((abort_reg & $past(abort_reg)) == $past(abort_reg)))
        else $error("abort flag cleared without restart");

    // The mismatch counter never goes down except on a restart.
    assert property (@(posedge clk) disable iff (!rst_n)
        !restart |=> (mismatches_reg >= $past(mismatches_reg)))
        else $error("mismatch count decreased");

    // A sector mismatch is reported only with the last verify word of a sector.
    assert property (@(posedge clk) disable iff (!rst_n)
        (commit.valid && !(commit.kind == spwv_pkg::KIND_VERIFY && commit.last_word))
        |=> !smis_reg)
        else $error("sector mismatch outside last verify word");
`endif

endmodule

`default_nettype wire

### hw/rtl/sector_pattern_write_verify.sv
// Top level of the sector pattern write/verify engine.
`default_nettype none

// Storage self-test engine. Each input transaction is a pattern word to generate,
// a read-back word to check, a write or read chunk outcome, or a restart, and it
// yields exactly one result transaction with the expected word and the current
// statistics. The block handles one transaction at a time: a generate or verify
// word goes through MAC1, MAC2 and DONE between acceptances, as the seed, the
// index term and the LCG step all pass through one shared 32x32 multiply-add
// unit in two steps before the commit cycle; chunk outcomes, restarts and unused
// kinds go to DONE. A result held on the output by a stalled consumer delays
// the commit of the following transaction until the result is taken. Words of a
// sector must arrive in order from index 0 and sectors must not be interleaved.
// The abort threshold may be written only while the block is idle.
module sector_pattern_write_verify #(
    parameter int unsigned SECTOR_WORDS = 128
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire spwv_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output spwv_pkg::out_item_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic          [7:0] cfg_wdata
);

    logic              mac_en;
    logic [31:0]       mac_a;
    logic [31:0]       mac_b;
    logic [31:0]       mac_c;
    logic [31:0]       mac_result;
    spwv_pkg::commit_t commit;

    spwv_mac u_mac (
        .clk    (clk),
        .en     (mac_en),
        .op_a   (mac_a),
        .op_b   (mac_b),
        .op_c   (mac_c),
        .result (mac_result)
    );

    spwv_ctrl #(
        .SECTOR_WORDS (SECTOR_WORDS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mac_en     (mac_en),
        .mac_a      (mac_a),
        .mac_b      (mac_b),
        .mac_c      (mac_c),
        .mac_result (mac_result),
        .commit     (commit)
    );

    spwv_stats u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .commit    (commit),
        .result    (out_data)
    );

`ifndef SYNTHESIS
    // Only one transaction is in flight: the block is busy right after an acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while busy");

    // A pending result is withdrawn only after the consumer took it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped without handshake");
`endif

endmodule

`default_nettype wire

### verif/tb_sector_pattern_write_verify.sv
// Self-checking testbench for the sector pattern write/verify engine.
`timescale 1ns / 1ps

module tb_sector_pattern_write_verify;

    localparam int          SECTOR_WORDS  = 128;
    localparam logic [6:0]  LAST_WORD     = 7'(SECTOR_WORDS - 1);
    localparam int          NUM_PHASES    = 6;
    localparam int          PHASE_ITEMS   = 270;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_AT_ITEM  = 400;
    localparam int          HOLD_CYCLES   = 600;
    localparam int          NO_CORRUPT    = -1;

    typedef enum logic [1:0] {
        RCV_ALWAYS,
        RCV_COIN,
        RCV_SPARSE,
        RCV_TOGGLE
    } rcv_mode_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    spwv_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    spwv_pkg::out_item_t out_data;
    logic                cfg_we    = 1'b0;
    logic [7:0]          cfg_wdata = 8'd0;

    sector_pattern_write_verify #(
        .SECTOR_WORDS(SECTOR_WORDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Predicted engine state.
    logic [31:0] gen_lcg;
    logic [31:0] cur_tag;
    logic        cur_bad;
    logic [7:0]  wr_run;
    logic [7:0]  rd_run;
    logic [31:0] wr_fail_cnt;
    logic [31:0] rd_fail_cnt;
    logic [31:0] bad_sector_cnt;
    logic [31:0] good_sector_cnt;
    logic [31:0] written_cnt;
    logic [31:0] first_wr_fail;
    logic [31:0] first_rd_fail;
    logic [31:0] wrap_addr;
    logic [31:0] wrap_word;
    logic        wr_fail_seen;
    logic        rd_fail_seen;
    logic        wrap_recorded;
    logic [1:0]  abort_bits;
    logic [7:0]  threshold_reg;

    spwv_pkg::in_item_t  pending_items[$];
    spwv_pkg::out_item_t expected_stats[$];

    int items_queued    = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int error_count     = 0;
    int verify_sectors  = 0;
    int burst_left      = 0;
    int gap_left        = 0;
    int hold_left       = 0;
    logic hold_armed    = 1'b1;
    rcv_mode_t rcv_mode = RCV_ALWAYS;
    int mode_left       = 0;

    function automatic logic [31:0] lcg_advance(input logic [31:0] addr,
                                                input logic [6:0] idx,
                                                input logic [31:0] prev);
        logic [31:0] x;
        x = prev;
        if (idx == 7'd0)
            x = addr * spwv_pkg::SEED_MUL + spwv_pkg::SEED_ADD;
        return x * spwv_pkg::LCG_MUL + spwv_pkg::LCG_ADD;
    endfunction

    function automatic logic [31:0] pattern_from(input logic [31:0] addr,
                                                 input logic [6:0] idx,
                                                 input logic [31:0] lcg);
        if (idx == 7'd0)
            return addr;
        if (idx == 7'd1)
            return ~addr;
        return lcg ^ (addr + {25'd0, idx} * spwv_pkg::GOLDEN);
    endfunction

    function automatic logic [31:0] saturating_add(input logic [31:0] a,
                                                   input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void clear_model();
        gen_lcg         = 32'd0;
        cur_tag         = 32'd0;
        cur_bad         = 1'b0;
        wr_run          = 8'd0;
        rd_run          = 8'd0;
        wr_fail_cnt     = 32'd0;
        rd_fail_cnt     = 32'd0;
        bad_sector_cnt  = 32'd0;
        good_sector_cnt = 32'd0;
        written_cnt     = 32'd0;
        first_wr_fail   = 32'hFFFF_FFFF;
        first_rd_fail   = 32'hFFFF_FFFF;
        wrap_addr       = 32'hFFFF_FFFF;
        wrap_word       = 32'd0;
        wr_fail_seen    = 1'b0;
        rd_fail_seen    = 1'b0;
        wrap_recorded   = 1'b0;
        abort_bits      = 2'b00;
    endfunction

    // A failed chunk extends the run; a run reaching the threshold sets the abort flag.
    function automatic logic [7:0] bump_run(input logic [7:0] run, input logic [1:0] flag);
        logic [7:0] r;
        r = run;
        if (r != spwv_pkg::RUN_MAX)
            r = r + 8'd1;
        if (r >= threshold_reg)
            abort_bits = abort_bits | flag;
        return r;
    endfunction

    function automatic spwv_pkg::out_item_t predict_stats(input spwv_pkg::in_item_t it);
        spwv_pkg::out_item_t r;
        logic [31:0] w;
        r = '0;
        w = 32'd0;
        case (it.kind)
            spwv_pkg::KIND_GENERATE, spwv_pkg::KIND_VERIFY:
            begin
                gen_lcg = lcg_advance(it.sector_address, it.word_index, gen_lcg);
                w = pattern_from(it.sector_address, it.word_index, gen_lcg);
                if (it.kind == spwv_pkg::KIND_VERIFY)
                begin
                    if (it.word_index == 7'd0)
                    begin
                        cur_tag = it.read_word;
                        cur_bad = (it.read_word != w);
                    end
                    else if (it.read_word != w)
                    begin
                        cur_bad = 1'b1;
                    end
                    if (it.word_index == LAST_WORD)
                    begin
                        r.sector_mismatch = cur_bad;
                        if (cur_bad)
                        begin
                            bad_sector_cnt = saturating_add(bad_sector_cnt, 32'd1);
                            if (!rd_fail_seen)
                            begin
                                rd_fail_seen  = 1'b1;
                                first_rd_fail = it.sector_address;
                            end
                            if (cur_tag != it.sector_address && !wrap_recorded)
                            begin
                                wrap_recorded = 1'b1;
                                wrap_addr     = it.sector_address;
                                wrap_word     = cur_tag;
                            end
                        end
                        else
                        begin
                            good_sector_cnt = saturating_add(good_sector_cnt, 32'd1);
                        end
                    end
                end
            end
            spwv_pkg::KIND_WRITE:
            begin
                if (it.io_ok)
                begin
                    wr_run      = 8'd0;
                    written_cnt = saturating_add(written_cnt, {24'd0, it.chunk_sectors});
                end
                else
                begin
                    wr_fail_cnt = saturating_add(wr_fail_cnt, 32'd1);
                    if (!wr_fail_seen)
                    begin
                        wr_fail_seen  = 1'b1;
                        first_wr_fail = it.sector_address;
                    end
                    wr_run = bump_run(wr_run, spwv_pkg::ABORT_WRITE);
                end
            end
            spwv_pkg::KIND_READ:
            begin
                if (it.io_ok)
                begin
                    rd_run = 8'd0;
                end
                else
                begin
                    rd_fail_cnt = saturating_add(rd_fail_cnt, 32'd1);
                    if (!rd_fail_seen)
                    begin
                        rd_fail_seen  = 1'b1;
                        first_rd_fail = it.sector_address;
                    end
                    rd_run = bump_run(rd_run, spwv_pkg::ABORT_READ);
                end
            end
            spwv_pkg::KIND_RESTART:
            begin
                clear_model();
            end
            default:
            begin
            end
        endcase
        r.pattern_word      = w;
        r.write_fail_count  = wr_fail_cnt;
        r.read_fail_count   = rd_fail_cnt;
        r.mismatch_count    = bad_sector_cnt;
        r.verified_count    = good_sector_cnt;
        r.written_count     = written_cnt;
        r.first_write_fail  = first_wr_fail;
        r.first_verify_fail = first_rd_fail;
        r.wrap_address      = wrap_addr;
        r.wrap_tag          = wrap_word;
        r.abort_flags       = abort_bits;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic spwv_pkg::in_item_t make_item(input logic [2:0] kind,
                                                     input logic [31:0] addr,
                                                     input logic [6:0] idx,
                                                     input logic [31:0] rd,
                                                     input logic ok,
                                                     input logic [7:0] cnt);
        spwv_pkg::in_item_t it;
        it.kind           = kind;
        it.sector_address = addr;
        it.word_index     = idx;
        it.read_word      = rd;
        it.io_ok          = ok;
        it.chunk_sectors  = cnt;
        return it;
    endfunction

    function automatic logic [31:0] pick_address();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'($urandom_range(0, 1023));
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(input spwv_pkg::in_item_t it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Words of one sector in order from index 0; a verify sector may carry one corrupted word.
    task automatic queue_sector(input logic [2:0] kind, input logic [31:0] addr,
                                input int nwords, input int corrupt_at);
        logic [31:0] lcg;
        logic [31:0] w;
        logic [31:0] mask;
        lcg = 32'd0;
        for (int i = 0; i < nwords; i++)
        begin
            lcg = lcg_advance(addr, 7'(i), lcg);
            w = pattern_from(addr, 7'(i), lcg);
            if (kind == spwv_pkg::KIND_GENERATE)
            begin
                w = $urandom;
            end
            else if (i == corrupt_at)
            begin
                mask = $urandom;
                if (mask == 32'd0)
                    mask = 32'd1;
                w = w ^ mask;
            end
            queue_item(make_item(kind, addr, 7'(i), w, 1'($urandom), 8'($urandom)));
        end
        if (kind == spwv_pkg::KIND_VERIFY && nwords == SECTOR_WORDS)
            verify_sectors++;
    endtask

    task automatic queue_chunk_run(input logic [2:0] kind, input int count, input int fail_pct);
        logic [31:0] addr;
        logic [7:0]  cnt;
        logic        ok;
        addr = pick_address();
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                cnt = 8'($urandom_range(129, 255));
            else
                cnt = 8'($urandom_range(0, 128));
            ok = ($urandom_range(1, 100) > fail_pct);
            queue_item(make_item(kind, addr, 7'($urandom), $urandom, ok, cnt));
            addr = addr + {24'd0, cnt};
        end
    endtask

    task automatic queue_random_phase(input int budget);
        int start;
        int sel;
        int corrupt;
        int len;
        start = items_queued;
        while (items_queued - start < budget)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                case ($urandom_range(0, 4))
                    0, 1:    corrupt = NO_CORRUPT;
                    2:       corrupt = 0;
                    3:       corrupt = SECTOR_WORDS - 1;
                    default: corrupt = $urandom_range(1, SECTOR_WORDS - 2);
                endcase
                queue_sector(spwv_pkg::KIND_VERIFY, pick_address(), SECTOR_WORDS, corrupt);
            end
            else if (sel < 40)
            begin
                len = $urandom_range(0, 1) ? SECTOR_WORDS : $urandom_range(1, SECTOR_WORDS - 1);
                queue_sector(spwv_pkg::KIND_GENERATE, pick_address(), len, NO_CORRUPT);
            end
            else if (sel < 45)
            begin
                // A sector cut short; the next sector reseeds at index 0.
                len = $urandom_range(1, SECTOR_WORDS - 1);
                corrupt = $urandom_range(0, 1) ? NO_CORRUPT : $urandom_range(0, len - 1);
                queue_sector(spwv_pkg::KIND_VERIFY, pick_address(), len, corrupt);
            end
            else if (sel < 80)
            begin
                queue_chunk_run($urandom_range(0, 1) ? spwv_pkg::KIND_WRITE
                                                     : spwv_pkg::KIND_READ,
                                $urandom_range(1, 24),
                                $urandom_range(0, 1) ? 100 : 30);
            end
            else if (sel < 95)
            begin
                len = $urandom_range(1, 6);
                for (int n = 0; n < len; n++)
                    queue_item(make_item(3'($urandom_range(0, 7)), pick_address(),
                                         7'($urandom), $urandom, 1'($urandom),
                                         8'($urandom)));
            end
            else
            begin
                queue_item(make_item(spwv_pkg::KIND_RESTART, $urandom, 7'($urandom), $urandom,
                                     1'($urandom), 8'($urandom)));
            end
        end
    endtask

    task automatic queue_directed();
        // Unused kinds leave the statistics alone.
        queue_item(make_item(3'd5, $urandom, 7'd0, $urandom, 1'b0, 8'd0));
        queue_item(make_item(3'd6, $urandom, 7'd64, $urandom, 1'b1, 8'd128));
        queue_item(make_item(3'd7, 32'hFFFF_FFFF, 7'h7F, 32'hFFFF_FFFF, 1'b1, 8'hFF));
        // A failure at the all-ones address still counts as recorded.
        queue_item(make_item(spwv_pkg::KIND_WRITE, 32'hFFFF_FFFF, 7'd0, 32'd0, 1'b0, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_WRITE, 32'd0, 7'd0, 32'd0, 1'b0, 8'd7));
        queue_item(make_item(spwv_pkg::KIND_WRITE, 32'd0, 7'd0, 32'd0, 1'b1, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_WRITE, 32'd0, 7'd0, 32'd0, 1'b1, 8'd128));
        queue_item(make_item(spwv_pkg::KIND_WRITE, 32'd128, 7'd0, 32'd0, 1'b1, 8'hFF));
        queue_item(make_item(spwv_pkg::KIND_READ, 32'hFFFF_FFFF, 7'd0, 32'd0, 1'b0, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_READ, 32'd5, 7'd0, 32'd0, 1'b0, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_READ, 32'd6, 7'd0, 32'd0, 1'b1, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_GENERATE, 32'hFFFF_FFFF, 7'd0, 32'd0, 1'b0, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_GENERATE, 32'hFFFF_FFFF, 7'd1, 32'd0, 1'b0, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_GENERATE, 32'hFFFF_FFFF, 7'd2, 32'd0, 1'b0, 8'd0));
        // Good tag and inverse, then a bad word; the last word closes the sector with no wrap.
        queue_item(make_item(spwv_pkg::KIND_VERIFY, 32'd0, 7'd0, 32'd0, 1'b0, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_VERIFY, 32'd0, 7'd1, 32'hFFFF_FFFF, 1'b0, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_VERIFY, 32'd0, 7'd2, 32'd0, 1'b0, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_VERIFY, 32'd0, LAST_WORD, 32'd0, 1'b0, 8'd0));
        // A tag that differs from its address is kept as the wrap tag.
        queue_item(make_item(spwv_pkg::KIND_VERIFY, 32'h1234_5678, 7'd0, 32'hDEAD_BEEF,
                             1'b0, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_VERIFY, 32'h1234_5678, LAST_WORD, 32'd0,
                             1'b0, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_RESTART, 32'hFFFF_FFFF, 7'h7F, 32'hFFFF_FFFF,
                             1'b1, 8'hFF));
        queue_item(make_item(spwv_pkg::KIND_READ, 32'd0, 7'd0, 32'd0, 1'b0, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_WRITE, 32'hFFFF_FFFF, 7'd0, 32'd0, 1'b0, 8'd0));
        queue_item(make_item(spwv_pkg::KIND_RESTART, 32'd0, 7'd0, 32'd0, 1'b0, 8'd0));
    endtask

    // Returns once every queued transaction has been taken and answered.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_stats.size() != 0);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        threshold_reg = value;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            error_count++;
            if (error_count <= 10)
                $display("Result %0d: %s expected %h, got %h",
                         results_checked, name, exp_v, act_v);
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk)
    begin : drive_proc
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_stats.push_back(predict_stats(in_data));
                items_accepted <= items_accepted + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // One long stall of the consumer so that the engine backs up into its input.
    always @(posedge clk)
    begin : hold_proc
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && items_accepted >= HOLD_AT_ITEM)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin : receive_proc
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rcv_mode  <= RCV_ALWAYS;
            mode_left <= 100;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rcv_mode  <= rcv_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(32, 256);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                case (rcv_mode)
                    RCV_ALWAYS: out_ready <= 1'b1;
                    RCV_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RCV_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:    out_ready <= ~out_ready;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin : check_proc
        spwv_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_stats.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("Result transaction with nothing expected: %h", out_data);
            end
            else
            begin
                want = expected_stats.pop_front();
                check_field("pattern_word", want.pattern_word, out_data.pattern_word);
                check_field("sector_mismatch", want.sector_mismatch, out_data.sector_mismatch);
                check_field("write_fail_count", want.write_fail_count,
                            out_data.write_fail_count);
                check_field("read_fail_count", want.read_fail_count, out_data.read_fail_count);
                check_field("mismatch_count", want.mismatch_count, out_data.mismatch_count);
                check_field("verified_count", want.verified_count, out_data.verified_count);
                check_field("written_count", want.written_count, out_data.written_count);
                check_field("first_write_fail", want.first_write_fail,
                            out_data.first_write_fail);
                check_field("first_verify_fail", want.first_verify_fail,
                            out_data.first_verify_fail);
                check_field("wrap_address", want.wrap_address, out_data.wrap_address);
                check_field("wrap_tag", want.wrap_tag, out_data.wrap_tag);
                check_field("abort_flags", want.abort_flags, out_data.abort_flags);
                results_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- sequence of the run

    initial
    begin : stimulus_proc
        logic [7:0] thresholds [NUM_PHASES];
        clear_model();
        threshold_reg = spwv_pkg::ABORT_THRESHOLD_RESET;
        thresholds[0] = spwv_pkg::ABORT_THRESHOLD_RESET;
        thresholds[1] = 8'd1;
        thresholds[2] = 8'hFF;
        thresholds[3] = 8'd0;
        thresholds[4] = 8'($urandom_range(2, 254));
        thresholds[5] = 8'd3;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        wait_for_drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p != 0)
            begin
                // The sender rests here until every result is back.
                wait_for_drain();
                repeat (SETTLE_CYCLES) @(posedge clk);
                write_threshold(thresholds[p]);
            end
            if (thresholds[p] == 8'hFF)
            begin
                // Runs long enough to saturate both run counters.
                queue_chunk_run(spwv_pkg::KIND_WRITE, 260, 100);
                queue_chunk_run(spwv_pkg::KIND_WRITE, 1, 0);
                queue_chunk_run(spwv_pkg::KIND_READ, 258, 100);
                queue_random_phase(60);
            end
            else
            begin
                queue_random_phase(PHASE_ITEMS);
            end
        end

        wait_for_drain();
        repeat (20) @(posedge clk);

        $display("Checked %0d result transactions across %0d abort thresholds,",
                 results_checked, NUM_PHASES);
        $display("including %0d full verify sectors and one long consumer stall.",
                 verify_sectors);
        if (error_count == 0 && expected_stats.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
